// ----- src/ptc_pkg.sv -----
// Shared constants, types and helpers for the pressure/temperature compensation unit.
// Holds calibration register codes, stage shift amounts and the round-toward-zero shift.
// No dependencies.
package ptc_pkg;

  localparam int CAL_COUNT  = 6;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int CAL_W      = 16;
  localparam int RAW_W      = 24;
  localparam int PRESS_W    = 26;
  localparam int TEMP_W     = 19;
  localparam int NSTAGE     = 8;

  // Reference temperature of the first-order result, in 0.01 degC
  localparam int TEMP_REF   = 2000;

  // Shift amounts of the signed divisions by powers of two
  localparam int SENS_SHIFT = 7;
  localparam int OFF_SHIFT  = 6;
  localparam int TEMP_SHIFT = 23;
  localparam int TI_SHIFT   = 35;
  localparam int OFFI_SHIFT = 3;
  localparam int SENSI_SHIFT = 5;
  localparam int PROD_SHIFT = 21;
  localparam int PRESS_SHIFT = 15;

  // Second-order correction weights
  localparam int TI_WEIGHT    = 11;
  localparam int OFFI_WEIGHT  = 31;
  localparam int SENSI_WEIGHT = 63;

  // Width of the low partial-product slice of the pressure multiply
  localparam int SPLIT_W = 19;

  typedef enum logic [2:0] {
    REG_SENS_BASE        = 3'd0,
    REG_OFFSET_BASE      = 3'd1,
    REG_SENS_TEMPCO      = 3'd2,
    REG_OFFSET_TEMPCO    = 3'd3,
    REG_REF_TEMPERATURE  = 3'd4,
    REG_TEMP_SENSITIVITY = 3'd5
  } cal_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] sens_base;
    logic [CAL_W-1:0] offset_base;
    logic [CAL_W-1:0] sens_tempco;
    logic [CAL_W-1:0] offset_tempco;
    logic [CAL_W-1:0] ref_temperature;
    logic [CAL_W-1:0] temp_sensitivity;
  } cal_t;

  // Signed shift right that truncates toward zero, as C integer division does
  function automatic logic signed [63:0] tz_shift(input logic signed [63:0] x,
                                                  input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ----- src/pressure_temperature_compensation_unit.sv -----
// Pressure/temperature compensation unit, top level: APB calibration registers and
// an eight-stage pipeline for the first- and second-order compensation.
// Depends on ptc_pkg.
//
// Throughput: one beat per cycle unless out_stall holds a full pipeline; the
// deepest product (24 x 38 bits) is split into two partial products so no multiply
// is wider than 25 x 25 bits.
// Reset: synchronous active-high rst clears all stage valid bits and the
// calibration words to zero; no clearing pass.
module pressure_temperature_compensation_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptc_pkg::DATA_W-1:0]   pwdata,
  output logic [ptc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ptc_pkg::RAW_W-1:0]    raw_pressure,
  input  logic [ptc_pkg::RAW_W-1:0]    raw_temperature,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ptc_pkg::PRESS_W-1:0] pressure_centi_mbar,
  output logic signed [ptc_pkg::TEMP_W-1:0]  temperature_centi_c
);
  import ptc_pkg::*;

  cal_t              cal;
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;
  logic              wr_en;
  cal_reg_t          reg_sel;

  // Stage payloads
  logic [RAW_W-1:0]           d1_1, d1_2, d1_3, d1_4, d1_5;
  logic signed [24:0]         dt_1;
  logic signed [41:0]         p_sens_2, p_off_2, p_temp_2;
  logic [48:0]                p_sq_2;
  logic signed [35:0]         sens_3, sens_4;
  logic signed [36:0]         off_3, off_4;
  logic signed [17:0]         dev_3;
  logic [16:0]                ti_3;
  logic                       low_3, low_4;
  logic [34:0]                devsq_4;
  logic [TEMP_W-1:0]          temp_4, temp_5, temp_6, temp_7;
  logic signed [37:0]         sadj_5;
  logic signed [38:0]         oadj_5, oadj_6, oadj_7;
  logic [42:0]                pp_lo_6;
  logic signed [43:0]         pp_hi_6;
  logic signed [41:0]         q_7;

  // Combinational results per stage
  logic signed [63:0] sens64, off64, dev64, prod64, q64, press64;
  logic [63:0]        ti64, temp64, offi64, sensi64, sadj64, oadj64;

  // ---------------- calibration registers ----------------
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cal_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      unique case (paddr[ADDR_W-1:2])
        REG_SENS_BASE:        cal.sens_base        <= pwdata[CAL_W-1:0];
        REG_OFFSET_BASE:      cal.offset_base      <= pwdata[CAL_W-1:0];
        REG_SENS_TEMPCO:      cal.sens_tempco      <= pwdata[CAL_W-1:0];
        REG_OFFSET_TEMPCO:    cal.offset_tempco    <= pwdata[CAL_W-1:0];
        REG_REF_TEMPERATURE:  cal.ref_temperature  <= pwdata[CAL_W-1:0];
        REG_TEMP_SENSITIVITY: cal.temp_sensitivity <= pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SENS_BASE:        prdata = DATA_W'(cal.sens_base);
      REG_OFFSET_BASE:      prdata = DATA_W'(cal.offset_base);
      REG_SENS_TEMPCO:      prdata = DATA_W'(cal.sens_tempco);
      REG_OFFSET_TEMPCO:    prdata = DATA_W'(cal.offset_tempco);
      REG_REF_TEMPERATURE:  prdata = DATA_W'(cal.ref_temperature);
      REG_TEMP_SENSITIVITY: prdata = DATA_W'(cal.temp_sensitivity);
      default:              prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // A stage loads when it is empty or its content moves on; bubbles collapse.
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    sens64  = 64'({cal.sens_base, 16'h0000}) + tz_shift(64'(p_sens_2), SENS_SHIFT);
    off64   = 64'({cal.offset_base, 17'h00000}) + tz_shift(64'(p_off_2), OFF_SHIFT);
    dev64   = tz_shift(64'(p_temp_2), TEMP_SHIFT);
    ti64    = (64'(p_sq_2) * 64'(TI_WEIGHT)) >> TI_SHIFT;

    temp64  = 64'(TEMP_REF) + 64'(dev_3) - (low_3 ? 64'(ti_3) : 64'd0);

    // Second-order terms only below the reference temperature
    offi64  = low_4 ? ((64'(devsq_4) * 64'(OFFI_WEIGHT)) >> OFFI_SHIFT) : 64'd0;
    sensi64 = low_4 ? ((64'(devsq_4) * 64'(SENSI_WEIGHT)) >> SENSI_SHIFT) : 64'd0;
    sadj64  = 64'(sens_4) - sensi64;
    oadj64  = 64'(off_4) - offi64;

    // Recombine the partial products of D1 * (SENS - SENSi)
    prod64  = (64'(pp_hi_6) <<< SPLIT_W) + signed'(64'(pp_lo_6));
    q64     = tz_shift(prod64, PROD_SHIFT);

    press64 = tz_shift(64'(q_7) - 64'(oadj_7), PRESS_SHIFT);
  end

  // Stage 1: temperature difference
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_1 <= raw_pressure;
      dt_1 <= signed'({1'b0, raw_temperature}) - signed'({1'b0, cal.ref_temperature, 8'h00});
    end
  end

  // Stage 2: first-order products and dT squared
  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_2     <= d1_1;
      p_sens_2 <= dt_1 * signed'({1'b0, cal.sens_tempco});
      p_off_2  <= dt_1 * signed'({1'b0, cal.offset_tempco});
      p_temp_2 <= dt_1 * signed'({1'b0, cal.temp_sensitivity});
      p_sq_2   <= 49'(dt_1 * dt_1);
    end
  end

  // Stage 3: first-order SENS, OFF and temperature deviation
  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_3   <= d1_2;
      sens_3 <= sens64[35:0];
      off_3  <= off64[36:0];
      dev_3  <= dev64[17:0];
      ti_3   <= ti64[16:0];
      low_3  <= dev64[63];
    end
  end

  // Stage 4: deviation squared, final temperature
  always_ff @(posedge clk) begin
    if (en[3]) begin
      d1_4    <= d1_3;
      sens_4  <= sens_3;
      off_4   <= off_3;
      low_4   <= low_3;
      devsq_4 <= 35'(dev_3 * dev_3);
      temp_4  <= temp64[TEMP_W-1:0];
    end
  end

  // Stage 5: apply second-order corrections
  always_ff @(posedge clk) begin
    if (en[4]) begin
      d1_5   <= d1_4;
      temp_5 <= temp_4;
      sadj_5 <= sadj64[37:0];
      oadj_5 <= oadj64[38:0];
    end
  end

  // Stage 6: partial products of the pressure multiply
  always_ff @(posedge clk) begin
    if (en[5]) begin
      temp_6  <= temp_5;
      oadj_6  <= oadj_5;
      pp_lo_6 <= d1_5 * sadj_5[SPLIT_W-1:0];
      pp_hi_6 <= signed'({1'b0, d1_5}) * signed'(sadj_5[37:SPLIT_W]);
    end
  end

  // Stage 7: recombine and scale
  always_ff @(posedge clk) begin
    if (en[6]) begin
      temp_7 <= temp_6;
      oadj_7 <= oadj_6;
      q_7    <= q64[41:0];
    end
  end

  // Stage 8: output register
  always_ff @(posedge clk) begin
    if (en[7]) begin
      pressure_centi_mbar <= press64[PRESS_W-1:0];
      temperature_centi_c <= temp_7;
    end
  end

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_stall))
    else $error("input stalled with room in the pipeline");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted beat did not reach the first stage");

  a_held_result_stays: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTAGE-1] && out_stall) |=> (vld[NSTAGE-1] && $stable(temperature_centi_c)))
    else $error("stalled result lost or changed");

  a_no_second_order_when_warm: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !low_4) |-> (offi64 == 64'd0 && sensi64 == 64'd0))
    else $error("second-order terms applied at or above reference temperature");

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for pressure_temperature_compensation_unit: calibration over APB,
// a directed table then randomised readings, checked against a local model of the maths.
// Depends on ptc_pkg and the unit's RTL.
module testbench;
  import ptc_pkg::*;

  localparam int LATENCY = 8;

  typedef struct packed {
    logic signed [PRESS_W-1:0] press;
    logic signed [TEMP_W-1:0]  temp;
  } reading_t;

  typedef enum int {PRESET_RESET, PRESET_FULL, PRESET_TYPICAL} preset_t;

  typedef struct {
    preset_t                   preset;
    logic [RAW_W-1:0]          p;
    logic [RAW_W-1:0]          t;
    bit                        typed;
    logic signed [PRESS_W-1:0] press;
    logic signed [TEMP_W-1:0]  temp;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      psel, penable, pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid, in_stall;
  logic [RAW_W-1:0]          raw_pressure, raw_temperature;
  logic                      out_valid, out_stall;
  logic signed [PRESS_W-1:0] pressure_centi_mbar;
  logic signed [TEMP_W-1:0]  temperature_centi_c;

  pressure_temperature_compensation_unit dut (.*);

  always #10 clk = ~clk;

  cal_t     cal_words = '0;
  reading_t pending_readings[$];
  bit       quiet = 1'b0;
  int       mismatches = 0;
  int       readings_checked = 0;
  int       cal_sets = 1;
  int       cold_readings = 0;

  cal_t cal_presets [3] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165}
  };

  // With all calibration words at zero every reading gives 0 mbar and 20.00 degC
  row_t directed_rows [19] = '{
    '{PRESET_RESET,   24'h000000, 24'h000000, 1'b1, 0, 2000},
    '{PRESET_RESET,   24'hFFFFFF, 24'hFFFFFF, 1'b1, 0, 2000},
    '{PRESET_RESET,   24'hFFFFFF, 24'h000000, 1'b1, 0, 2000},
    '{PRESET_RESET,   24'h000000, 24'hFFFFFF, 1'b1, 0, 2000},
    '{PRESET_RESET,   24'hAAAAAA, 24'h555555, 1'b1, 0, 2000},
    '{PRESET_FULL,    24'h000000, 24'h000000, 1'b0, 0, 0},
    '{PRESET_FULL,    24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
    '{PRESET_FULL,    24'hFFFFFF, 24'hFFFFFF, 1'b0, 0, 0},
    '{PRESET_FULL,    24'h000000, 24'hFFFFFF, 1'b0, 0, 0},
    '{PRESET_FULL,    24'h800000, 24'hFFFF00, 1'b0, 0, 0},
    '{PRESET_FULL,    24'h123456, 24'hFFFF01, 1'b0, 0, 0},
    '{PRESET_FULL,    24'h123456, 24'hFFFEFF, 1'b0, 0, 0},
    '{PRESET_FULL,    24'h555555, 24'h7FFFFF, 1'b0, 0, 0},
    '{PRESET_FULL,    24'hFFFFFF, 24'hFFFE7F, 1'b0, 0, 0},
    '{PRESET_TYPICAL, 24'h4A2B1C, 24'h7B5E80, 1'b0, 0, 0},
    '{PRESET_TYPICAL, 24'h4A2B1C, 24'h600000, 1'b0, 0, 0},
    '{PRESET_TYPICAL, 24'h4A2B1C, 24'hA00000, 1'b0, 0, 0},
    '{PRESET_TYPICAL, 24'h000001, 24'h7B4100, 1'b0, 0, 0},
    '{PRESET_TYPICAL, 24'h800000, 24'h000001, 1'b0, 0, 0}
  };

  // Second-order compensation; SV signed division truncates toward zero as required
  function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, sens, off, temp, dev, ti, offi, sensi, press;
    reading_t r;
    d1 = {40'd0, d1_raw};
    d2 = {40'd0, d2_raw};
    c1 = {48'd0, cal_words.sens_base};
    c2 = {48'd0, cal_words.offset_base};
    c3 = {48'd0, cal_words.sens_tempco};
    c4 = {48'd0, cal_words.offset_tempco};
    c5 = {48'd0, cal_words.ref_temperature};
    c6 = {48'd0, cal_words.temp_sensitivity};
    dt   = d2 - c5 * 64'sd256;
    sens = c1 * 64'sd65536 + (c3 * dt) / 64'sd128;
    off  = c2 * 64'sd131072 + (c4 * dt) / 64'sd64;
    temp = 64'sd2000 + (dt * c6) / 64'sd8388608;
    ti = 0;
    offi = 0;
    sensi = 0;
    if (temp < 64'sd2000) begin
      dev   = temp - 64'sd2000;
      ti    = (64'sd11 * dt * dt) / 64'sd34359738368;
      offi  = (64'sd31 * dev * dev) / 64'sd8;
      sensi = (64'sd63 * dev * dev) / 64'sd32;
    end
    temp  = temp - ti;
    press = ((d1 * (sens - sensi)) / 64'sd2097152 - (off - offi)) / 64'sd32768;
    r.press = press[PRESS_W-1:0];
    r.temp  = temp[TEMP_W-1:0];
    return r;
  endfunction

  task automatic write_cal(input int unsigned idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << 2);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk);
    // only the low half of the word lands; unknown indexes are dropped
    case (idx)
      REG_SENS_BASE:        cal_words.sens_base        = value[CAL_W-1:0];
      REG_OFFSET_BASE:      cal_words.offset_base      = value[CAL_W-1:0];
      REG_SENS_TEMPCO:      cal_words.sens_tempco      = value[CAL_W-1:0];
      REG_OFFSET_TEMPCO:    cal_words.offset_tempco    = value[CAL_W-1:0];
      REG_REF_TEMPERATURE:  cal_words.ref_temperature  = value[CAL_W-1:0];
      REG_TEMP_SENSITIVITY: cal_words.temp_sensitivity = value[CAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_cal(input cal_t c);
    write_cal(REG_SENS_BASE,        {16'($urandom), c.sens_base});
    write_cal(REG_OFFSET_BASE,      {16'($urandom), c.offset_base});
    write_cal(REG_SENS_TEMPCO,      {16'($urandom), c.sens_tempco});
    write_cal(REG_OFFSET_TEMPCO,    {16'($urandom), c.offset_tempco});
    write_cal(REG_REF_TEMPERATURE,  {16'($urandom), c.ref_temperature});
    write_cal(REG_TEMP_SENSITIVITY, {16'($urandom), c.temp_sensitivity});
    cal_sets++;
  endtask

  // Drop valid, wait for every outstanding reading, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                              input bit typed, input reading_t typed_exp);
    reading_t exp_r;
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_pressure    <= p;
    raw_temperature <= t;
    do @(posedge clk); while (in_stall);
    exp_r = typed ? typed_exp : compensate(p, t);
    if (t < {cal_words.ref_temperature, 8'h00}) cold_readings++;
    pending_readings.push_back(exp_r);
  endtask

  function automatic logic [CAL_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: press %0d temp %0d",
                     pressure_centi_mbar, temperature_centi_c);
        end else begin
          reading_t exp_r;
          exp_r = pending_readings.pop_front();
          readings_checked++;
          if (exp_r.press !== pressure_centi_mbar || exp_r.temp !== temperature_centi_c) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: press exp %0d got %0d, temp exp %0d got %0d",
                       exp_r.press, pressure_centi_mbar, exp_r.temp, temperature_centi_c);
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  initial begin
    logic [RAW_W-1:0] p, t;
    cal_t c;
    preset_t current;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid        <= 1'b0;
    raw_pressure    <= '0;
    raw_temperature <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    current = PRESET_RESET;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].preset != current) begin
        settle();
        current = directed_rows[i].preset;
        program_cal(cal_presets[current]);
      end
      send_reading(directed_rows[i].p, directed_rows[i].t, directed_rows[i].typed,
                   '{directed_rows[i].press, directed_rows[i].temp});
    end

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      quiet = (phase == 3);
      c = '{pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
      program_cal(c);
      // a stray write past the last register must leave the calibration alone
      write_cal(CAL_COUNT + $urandom_range(1), $urandom);
      repeat (50) begin
        p = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : RAW_W'($urandom);
        case ($urandom_range(3))
          0: t = RAW_W'($urandom);
          1: t = RAW_W'({cal_words.ref_temperature, 8'h00} + $urandom_range(8191) - 4096);
          2: t = RAW_W'($urandom_range({cal_words.ref_temperature, 8'h00}));
          default: t = $urandom_range(1) ? '1 : '0;
        endcase
        send_reading(p, t, 1'b0, '0);
      end
    end
    quiet = 1'b0;
    settle();

    $display("%0d readings checked across %0d calibration sets, %0d below reference",
             readings_checked, cal_sets, cold_readings);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/ptc_pkg.sv
src/pressure_temperature_compensation_unit.sv
tb/testbench.sv
